// ----- hdl/kfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfe_pkg
// Shared types, codes and the constant sine table of the keyframe
// interpolator.
// ----------------------------------------------------------------------------
package kfe_pkg;

    // Request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    // Curve codes
    localparam logic [2:0] CURVE_LINEAR  = 3'd0;
    localparam logic [2:0] CURVE_SMOOTH  = 3'd1;
    localparam logic [2:0] CURVE_IN      = 3'd2;
    localparam logic [2:0] CURVE_OUT     = 3'd3;
    localparam logic [2:0] CURVE_INOUT   = 3'd4;
    localparam logic [2:0] CURVE_BOUNCE  = 3'd5;
    localparam logic [2:0] CURVE_ELASTIC = 3'd6;

    // Register index (byte address bit 2)
    localparam logic REG_KEY_COUNT = 1'b0;

    // Sine table over one full turn, Q16 entries
    localparam int SINE_BITS  = 8;
    localparam int SINE_DEPTH = 256;

    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [17:0] t_sine_tab [SINE_DEPTH];

    // One keyframe as held in the table
    typedef struct packed {
        logic [31:0]        tq;
        logic signed [15:0] value;
        logic [2:0]         curve;
    } t_key;

    // Quadrant folding and a Taylor series in Q30, rounded to Q16
    function automatic logic signed [17:0] sine_entry(input int k);
        logic [63:0] q4;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] f;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] mag;
        q4   = 64'(k) * 64'd4;
        quad = (q4 / SINE_DEPTH) & 64'd3;
        r    = q4 % SINE_DEPTH;
        f    = quad[0] ? 64'(SINE_DEPTH) - r : r;
        x    = HALF_PI_Q30 * f / SINE_DEPTH;
        x2   = (x * x) >> 30;
        p    = ONE_Q30 - x2 / 110;
        p    = ONE_Q30 - ((x2 * p) >> 30) / 72;
        p    = ONE_Q30 - ((x2 * p) >> 30) / 42;
        p    = ONE_Q30 - ((x2 * p) >> 30) / 20;
        p    = ONE_Q30 - ((x2 * p) >> 30) / 6;
        s    = (x * p) >> 30;
        mag  = (s + 64'd8192) >> 14;
        if (mag > 64'd65536) mag = 64'd65536;
        return (quad >= 64'd2) ? -$signed(18'(mag)) : $signed(18'(mag));
    endfunction

    function automatic t_sine_tab build_sine();
        t_sine_tab tab;
        for (int k = 0; k < SINE_DEPTH; k++) tab[k] = sine_entry(k);
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

endpackage

// ----- hdl/kfe_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfe_ram
// Generic simple dual-port RAM (one write port, one read port) with a registered read.
// ----------------------------------------------------------------------------
module kfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/kfe_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfe_div
// Interpolation factor t = (time - ta) / (tb - ta) in Q16, one quotient bit
// per cycle, limited to 1.0 and zero for an empty span.
// ----------------------------------------------------------------------------
module kfe_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_time,
    input  logic [31:0] i_ta,
    input  logic [31:0] i_tb,
    output logic        o_done,
    output logic [16:0] o_t
);

    logic        r_run;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_span;
    logic [15:0] r_quo;
    logic [16:0] r_t;

    logic [31:0] num;
    logic [31:0] span;
    logic [32:0] rem2;
    logic        take;
    logic [15:0] quo_nx;

    assign num    = i_time - i_ta;
    assign span   = i_tb - i_ta;
    assign rem2   = {r_rem[31:0], 1'b0};
    assign take   = rem2 >= {1'b0, r_span};
    assign quo_nx = {r_quo[14:0], take};

    // Control: start, iterate, finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_tb <= i_ta || num >= span) begin
                    r_done <= 1'b1;
                end else begin
                    r_run <= 1'b1;
                    r_cnt <= 5'd16;
                end
            end else if (r_run) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: restoring division step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, num};
            r_span <= span;
            r_quo  <= '0;
            if (i_tb <= i_ta) begin
                r_t <= '0;
            end else if (num >= span) begin
                r_t <= 17'd65536;
            end
        end else if (r_run) begin
            r_rem <= take ? rem2 - {1'b0, r_span} : rem2;
            r_quo <= quo_nx;
            r_t   <= {1'b0, quo_nx};
        end
    end

    assign o_done = r_done;
    assign o_t    = r_t;

endmodule

// ----- hdl/keyframe_easing_interpolator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_easing_interpolator_core
// Keyframe table with eased linear interpolation between bracketing keys.
// ----------------------------------------------------------------------------
// A load beat writes one keyframe and leaves busy low. An evaluate beat on
// an empty table answers in the next cycle. Otherwise busy rises: a query
// that clamps to key 0, or a table with a single key, ends in S_K0; one that
// clamps to the last key ends in S_KL; one that interpolates goes on through
// the search, the divider, the multiplier states and S_FIN. The key table is
// one RAM read port walked one key a cycle, the factor comes from a
// one-bit-per-cycle divider, and one shared 20x20 multiplier does the curve
// and the final blend in turn. The result is on the outputs with o_valid for
// the one cycle in which busy has just fallen; it cannot be held off, and a
// new beat may start in that same cycle.
module keyframe_easing_interpolator_core #(
    parameter int MAX_KEYS   = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic [3:0]         i_key_index,
    input  logic [31:0]        i_key_time,
    input  logic signed [15:0] i_key_value,
    input  logic [2:0]         i_key_curve,
    input  logic [31:0]        i_eval_time,
    output logic               o_valid,
    output logic signed [15:0] o_out_value,
    output logic               o_empty_track,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int SB = kfe_pkg::SINE_BITS;
    localparam logic signed [39:0] SAT_HI = (40'sd1 <<< (VALUE_BITS - 1)) - 40'sd1;
    localparam logic signed [39:0] SAT_LO = -SAT_HI - 40'sd1;

    typedef enum logic [3:0] {
        S_IDLE, S_K0, S_KL, S_SRCH, S_DIVGO, S_DIVW,
        S_M1, S_C1, S_M2, S_C2, S_MF, S_FIN
    } t_state;

    t_state              r_state, n_state;
    logic [4:0]          r_key_count;
    logic [CW-1:0]       r_n, n_n;
    logic [CW-1:0]       r_idx, n_idx;
    logic [31:0]         r_time, n_time;
    kfe_pkg::t_key       r_ka, n_ka, r_kb, n_kb, r_k0, n_k0, r_k1, n_k1;
    logic [16:0]         r_t, n_t;
    logic signed [19:0]  r_c, n_c;
    logic signed [39:0]  r_prod;
    logic                r_valid, n_valid;
    logic signed [15:0]  r_value, n_value;
    logic                r_empty, n_empty;

    logic                accept;
    logic                cfg_wr;
    logic [CW-1:0]       n_eff;
    logic [CW-1:0]       idx_inc;
    logic [CW-1:0]       last_idx;
    logic [AW-1:0]       raddr;
    logic                we;
    kfe_pkg::t_key       wkey;
    kfe_pkg::t_key       rkey;
    logic                div_start;
    logic                div_done;
    logic [16:0]         div_t;
    logic [16:0]         u;
    logic                t_low;
    logic [18+SB:0]      sh_b;
    logic [18+SB:0]      sh_e;
    logic signed [17:0]  s_b;
    logic signed [17:0]  s_e;
    logic signed [19:0]  s_b_abs;
    logic signed [19:0]  mul_a;
    logic signed [19:0]  mul_b;
    logic signed [23:0]  pq;
    logic signed [23:0]  p15;
    logic signed [24:0]  res;
    logic signed [39:0]  res40;

    assign accept   = start && !busy;
    assign busy     = r_state != S_IDLE;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == kfe_pkg::REG_KEY_COUNT) ? {27'd0, r_key_count} : 32'd0;
    assign n_eff    = ({27'd0, r_key_count} > 32'(MAX_KEYS)) ? CW'(MAX_KEYS)
                                                             : CW'(r_key_count);
    assign idx_inc  = CW'(r_idx + 1'b1);
    assign last_idx = CW'(r_n - 1'b1);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
        end else if (cfg_wr && paddr[2] == kfe_pkg::REG_KEY_COUNT) begin
            r_key_count <= pwdata[4:0];
        end
    end

    // Key table
    assign we = accept && i_req_type == kfe_pkg::REQ_LOAD
                && ({28'd0, i_key_index} < 32'(MAX_KEYS));
    assign wkey = '{tq: i_key_time, value: i_key_value, curve: i_key_curve};

    always_comb begin
        unique case (r_state)
            S_K0:    raddr = last_idx[AW-1:0];
            S_KL:    raddr = AW'(1);
            S_SRCH:  raddr = idx_inc[AW-1:0];
            default: raddr = '0;
        endcase
    end

    kfe_ram #(
        .WIDTH ($bits(kfe_pkg::t_key)),
        .DEPTH (MAX_KEYS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (AW'(i_key_index)),
        .i_wdata (wkey),
        .i_raddr (raddr),
        .o_rdata (rkey)
    );

    // Factor divider
    assign div_start = r_state == S_DIVGO;

    kfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_time  (r_time),
        .i_ta    (r_ka.tq),
        .i_tb    (r_kb.tq),
        .o_done  (div_done),
        .o_t     (div_t)
    );

    // Curve helpers
    assign u       = 17'd65536 - r_t;
    assign t_low   = r_t < 17'd32768;
    assign sh_b    = (SB + 19)'(r_t) << (SB + 1);
    assign sh_e    = (SB + 19)'(r_t) << (SB + 2);
    assign s_b     = kfe_pkg::SINE_TAB[sh_b[16 +: SB]];
    assign s_e     = kfe_pkg::SINE_TAB[sh_e[16 +: SB]];
    assign s_b_abs = (s_b < 0) ? -20'(s_b) : 20'(s_b);
    assign pq      = r_prod[39:16];
    assign p15     = r_prod[38:15];

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_M1: begin
                case (r_ka.curve) inside
                    kfe_pkg::CURVE_SMOOTH, kfe_pkg::CURVE_IN: begin
                        mul_a = 20'(r_t);
                        mul_b = 20'(r_t);
                    end
                    kfe_pkg::CURVE_OUT: begin
                        mul_a = 20'(u);
                        mul_b = 20'(u);
                    end
                    kfe_pkg::CURVE_INOUT: begin
                        mul_a = t_low ? 20'(r_t) : 20'(u);
                        mul_b = t_low ? 20'(r_t) : 20'(u);
                    end
                    kfe_pkg::CURVE_BOUNCE: begin
                        mul_a = s_b_abs;
                        mul_b = 20'(u);
                    end
                    kfe_pkg::CURVE_ELASTIC: begin
                        mul_a = 20'(s_e);
                        mul_b = 20'(u);
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_M2: begin
                mul_a = r_c;
                mul_b = 20'sd196608 - 20'({r_t, 1'b0});
            end
            S_MF: begin
                mul_a = 20'(r_kb.value) - 20'(r_ka.value);
                mul_b = r_c;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    assign res   = 25'(r_ka.value) + 25'(pq);
    assign res40 = 40'(res);

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_idx   = r_idx;
        n_time  = r_time;
        n_ka    = r_ka;
        n_kb    = r_kb;
        n_k0    = r_k0;
        n_k1    = r_k1;
        n_t     = r_t;
        n_c     = r_c;
        n_valid = 1'b0;
        n_value = r_value;
        n_empty = r_empty;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_req_type == kfe_pkg::REQ_EVAL) begin
                    n_n    = n_eff;
                    n_time = i_eval_time;
                    if (n_eff == '0) begin
                        n_valid = 1'b1;
                        n_value = '0;
                        n_empty = 1'b1;
                    end else begin
                        n_state = S_K0;
                    end
                end
            end
            S_K0: begin
                n_ka = rkey;
                n_k0 = rkey;
                if (r_n == CW'(1) || r_time <= rkey.tq) begin
                    n_value = rkey.value;
                    n_empty = 1'b0;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_KL;
                end
            end
            S_KL: begin
                if (r_time >= rkey.tq) begin
                    n_value = rkey.value;
                    n_empty = 1'b0;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx   = CW'(1);
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_idx == CW'(1)) n_k1 = rkey;
                if (r_time >= r_ka.tq && r_time <= rkey.tq) begin
                    n_kb    = rkey;
                    n_state = S_DIVGO;
                end else if (idx_inc < r_n) begin
                    n_ka  = rkey;
                    n_idx = idx_inc;
                end else begin
                    // no bracketing pair: fall back to the first pair
                    n_ka    = r_k0;
                    n_kb    = (r_idx == CW'(1)) ? rkey : r_k1;
                    n_state = S_DIVGO;
                end
            end
            S_DIVGO: n_state = S_DIVW;
            S_DIVW: begin
                if (div_done) begin
                    n_t     = div_t;
                    n_state = S_M1;
                end
            end
            S_M1: n_state = S_C1;
            S_C1: begin
                n_state = S_MF;
                case (r_ka.curve)
                    kfe_pkg::CURVE_SMOOTH: begin
                        n_c     = 20'(pq);
                        n_state = S_M2;
                    end
                    kfe_pkg::CURVE_IN:      n_c = 20'(pq);
                    kfe_pkg::CURVE_OUT:     n_c = 20'sd65536 - 20'(pq);
                    kfe_pkg::CURVE_INOUT:   n_c = t_low ? 20'(p15) : 20'sd65536 - 20'(p15);
                    kfe_pkg::CURVE_BOUNCE:  n_c = 20'sd65536 - 20'(pq);
                    kfe_pkg::CURVE_ELASTIC: n_c = 20'(pq) + 20'(r_t);
                    default:                n_c = 20'(r_t);
                endcase
            end
            S_M2: n_state = S_C2;
            S_C2: begin
                n_c     = 20'(pq);
                n_state = S_MF;
            end
            S_MF: n_state = S_FIN;
            S_FIN: begin
                if (res40 > SAT_HI) begin
                    n_value = SAT_HI[15:0];
                end else if (res40 < SAT_LO) begin
                    n_value = SAT_LO[15:0];
                end else begin
                    n_value = res40[15:0];
                end
                n_empty = 1'b0;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_idx   <= n_idx;
            r_n     <= n_n;
        end
        r_time  <= n_time;
        r_ka    <= n_ka;
        r_kb    <= n_kb;
        r_k0    <= n_k0;
        r_k1    <= n_k1;
        r_t     <= n_t;
        r_c     <= n_c;
        r_value <= n_value;
        r_empty <= n_empty;
    end

    assign o_valid       = r_valid;
    assign o_out_value   = r_value;
    assign o_empty_track = r_empty;

endmodule

// ----- hdl/kfe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfe_checker
// Port-level checks on the interpolator's command and result behaviour.
// ----------------------------------------------------------------------------
module kfe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_req_type,
    input logic               o_valid,
    input logic               o_empty_track,
    input logic signed [15:0] o_out_value
);

    // An empty track always reports zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_track |-> o_out_value == 16'sd0)
        else $error("empty track with nonzero value");

    // An evaluate beat either starts work or answers at once
    a_eval_acts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_type == kfe_pkg::REQ_EVAL |=> busy || o_valid)
        else $error("evaluate beat dropped");

    // A load beat gives no result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_type == kfe_pkg::REQ_LOAD |=> !o_valid)
        else $error("result after load beat");

    // Finishing work always delivers a result
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_valid && !o_empty_track)
        else $error("work finished without a result");

endmodule

bind keyframe_easing_interpolator_core kfe_checker u_kfe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_req_type    (i_req_type),
    .o_valid       (o_valid),
    .o_empty_track (o_empty_track),
    .o_out_value   (o_out_value)
);
